// File: design/gpp_pkg.sv
`timescale 1ns / 1ps

package gpp_pkg;

	// word and divider widths, the divisor covers the square root of any word
	localparam int NUM_W = 16;
	localparam int DIV_W = NUM_W / 2 + 1;
	localparam int SQ_W  = 2 * DIV_W;
	localparam int CNT_W = $clog2(NUM_W);

	// smallest prime, first candidate and first trial divisor
	localparam logic [NUM_W-1:0] MIN_PRIME = NUM_W'(2);

	// result status codes
	localparam logic [1:0] ST_PAIR  = 2'd0;
	localparam logic [1:0] ST_SMALL = 2'd1;
	localparam logic [1:0] ST_ODD   = 2'd2;

	// sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_TEST,
		S_DIV
	} state_t;

	// one action of the sequencer per cycle
	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_LOAD,
		ACT_REJECT,
		ACT_TEST_B,
		ACT_FOUND,
		ACT_NEXT_A,
		ACT_NO_PAIR,
		ACT_DIV_START,
		ACT_DIV_STEP,
		ACT_DIV_NEXT_D
	} act_t;

endpackage

// File: design/goldbach_prime_pair.sv
`timescale 1ns / 1ps

// Splits an even number above two into primes small_prime + large_prime with
// the smallest possible small_prime; numbers of two or less give status 1,
// odd numbers status 2, both with zero primes. A word is taken when start is
// high and busy is low; the result appears for one cycle with done high and
// must be captured then, as the receiver cannot stall it. Rejected numbers
// answer in the cycle after start. Otherwise candidates a = 2, 3 and upward and
// their complements are tested by trial division through one shared bit-serial
// remainder unit: each trial divisor takes one bound check and 16 shift-subtract
// steps. busy stays high for the whole search.
module goldbach_prime_pair (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [gpp_pkg::NUM_W-1:0] number,
	output logic                      done,
	output logic [1:0]                status,
	output logic [gpp_pkg::NUM_W-1:0] small_prime,
	output logic [gpp_pkg::NUM_W-1:0] large_prime
);

	gpp_pkg::state_t state_q, state_nxt;
	gpp_pkg::act_t   act;

	logic [gpp_pkg::NUM_W-1:0] n_q, half_q, a_q, v_q;
	logic                      which_q;
	logic [gpp_pkg::DIV_W-1:0] d_q, rem_q;
	logic [gpp_pkg::CNT_W-1:0] bit_q;

	logic                      done_q;
	logic [1:0]                status_q;
	logic [gpp_pkg::NUM_W-1:0] small_q, large_q;

	logic [gpp_pkg::SQ_W-1:0]  sq;
	logic                      v_small, sq_over, a_last;
	logic [gpp_pkg::DIV_W:0]   rem_shift;
	logic                      rem_ge;
	logic [gpp_pkg::DIV_W-1:0] rem_next;
	logic                      div_last, div_zero;
	logic                      reject_in;
	logic [1:0]                reject_st;

	// shared unit: divisor bound check and one remainder bit per cycle
	assign sq        = d_q * d_q;
	assign v_small   = v_q < gpp_pkg::MIN_PRIME;
	assign sq_over   = sq > gpp_pkg::SQ_W'(v_q);
	assign a_last    = a_q >= half_q;
	assign rem_shift = {rem_q, v_q[bit_q]};
	assign rem_ge    = rem_shift >= {1'b0, d_q};
	assign rem_next  = rem_ge ? gpp_pkg::DIV_W'(rem_shift - {1'b0, d_q})
	                          : rem_shift[gpp_pkg::DIV_W-1:0];
	assign div_last  = bit_q == '0;
	assign div_zero  = rem_next == '0;

	// input classification
	assign reject_in = (number <= gpp_pkg::MIN_PRIME) || number[0];
	assign reject_st = (number <= gpp_pkg::MIN_PRIME) ? gpp_pkg::ST_SMALL
	                                                  : gpp_pkg::ST_ODD;

	// sequencer action
	always_comb begin
		act = gpp_pkg::ACT_NONE;
		unique case (state_q)
			gpp_pkg::S_IDLE: begin
				if (start) begin
					act = reject_in ? gpp_pkg::ACT_REJECT : gpp_pkg::ACT_LOAD;
				end
			end
			gpp_pkg::S_TEST: begin
				if (v_small) begin
					act = a_last ? gpp_pkg::ACT_NO_PAIR : gpp_pkg::ACT_NEXT_A;
				end else if (sq_over) begin
					act = which_q ? gpp_pkg::ACT_FOUND : gpp_pkg::ACT_TEST_B;
				end else begin
					act = gpp_pkg::ACT_DIV_START;
				end
			end
			gpp_pkg::S_DIV: begin
				if (!div_last) begin
					act = gpp_pkg::ACT_DIV_STEP;
				end else if (div_zero) begin
					act = a_last ? gpp_pkg::ACT_NO_PAIR : gpp_pkg::ACT_NEXT_A;
				end else begin
					act = gpp_pkg::ACT_DIV_NEXT_D;
				end
			end
			default: act = gpp_pkg::ACT_NONE;
		endcase
	end

	// next state
	always_comb begin
		unique case (act)
			gpp_pkg::ACT_NONE:       state_nxt = state_q;
			gpp_pkg::ACT_LOAD:       state_nxt = gpp_pkg::S_TEST;
			gpp_pkg::ACT_REJECT:     state_nxt = gpp_pkg::S_IDLE;
			gpp_pkg::ACT_TEST_B:     state_nxt = gpp_pkg::S_TEST;
			gpp_pkg::ACT_FOUND:      state_nxt = gpp_pkg::S_IDLE;
			gpp_pkg::ACT_NEXT_A:     state_nxt = gpp_pkg::S_TEST;
			gpp_pkg::ACT_NO_PAIR:    state_nxt = gpp_pkg::S_IDLE;
			gpp_pkg::ACT_DIV_START:  state_nxt = gpp_pkg::S_DIV;
			gpp_pkg::ACT_DIV_STEP:   state_nxt = gpp_pkg::S_DIV;
			gpp_pkg::ACT_DIV_NEXT_D: state_nxt = gpp_pkg::S_TEST;
			default:                 state_nxt = gpp_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gpp_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// search datapath
	always_ff @(posedge clk) begin
		unique case (act)
			gpp_pkg::ACT_LOAD: begin
				n_q     <= number;
				half_q  <= number >> 1;
				a_q     <= gpp_pkg::MIN_PRIME;
				v_q     <= gpp_pkg::MIN_PRIME;
				which_q <= 1'b0;
				d_q     <= gpp_pkg::DIV_W'(gpp_pkg::MIN_PRIME);
			end
			gpp_pkg::ACT_TEST_B: begin
				v_q     <= n_q - a_q;
				which_q <= 1'b1;
				d_q     <= gpp_pkg::DIV_W'(gpp_pkg::MIN_PRIME);
			end
			gpp_pkg::ACT_NEXT_A: begin
				a_q     <= a_q + 1'b1;
				v_q     <= a_q + 1'b1;
				which_q <= 1'b0;
				d_q     <= gpp_pkg::DIV_W'(gpp_pkg::MIN_PRIME);
			end
			gpp_pkg::ACT_DIV_START: begin
				rem_q <= '0;
				bit_q <= gpp_pkg::CNT_W'(gpp_pkg::NUM_W - 1);
			end
			gpp_pkg::ACT_DIV_STEP: begin
				rem_q <= rem_next;
				bit_q <= bit_q - 1'b1;
			end
			gpp_pkg::ACT_DIV_NEXT_D: begin
				d_q <= d_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	// result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (act == gpp_pkg::ACT_REJECT) || (act == gpp_pkg::ACT_FOUND) ||
			          (act == gpp_pkg::ACT_NO_PAIR);
		end
	end

	always_ff @(posedge clk) begin
		if (act == gpp_pkg::ACT_REJECT) begin
			status_q <= reject_st;
			small_q  <= '0;
			large_q  <= '0;
		end else if (act == gpp_pkg::ACT_FOUND) begin
			status_q <= gpp_pkg::ST_PAIR;
			small_q  <= a_q;
			large_q  <= v_q;
		end else if (act == gpp_pkg::ACT_NO_PAIR) begin
			status_q <= gpp_pkg::ST_PAIR;
			small_q  <= '0;
			large_q  <= '0;
		end
	end

	assign busy        = state_q != gpp_pkg::S_IDLE;
	assign done        = done_q;
	assign status      = status_q;
	assign small_prime = small_q;
	assign large_prime = large_q;

	// a trial division only runs for divisors within the square-root bound
	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == gpp_pkg::S_DIV |-> (d_q >= 2) && (sq <= gpp_pkg::SQ_W'(v_q)))
		else $error("trial divisor out of range");

	// the remainder unit keeps going until its last bit
	a_div_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gpp_pkg::S_DIV) && !div_last |=> state_q == gpp_pkg::S_DIV)
		else $error("division left early");

	// a found pair adds up to the number and is ordered
	a_pair_sum: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && (status_q == gpp_pkg::ST_PAIR) && (small_q != '0) |->
		(gpp_pkg::NUM_W'(small_q + large_q) == n_q) && (small_q <= large_q))
		else $error("pair does not match number");

	// a result only follows a start or a search
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(start) || ($past(state_q) != gpp_pkg::S_IDLE))
		else $error("result without work");

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

	// expected partition of one word
	typedef struct packed {
		logic [1:0]                status;
		logic [gpp_pkg::NUM_W-1:0] small_p;
		logic [gpp_pkg::NUM_W-1:0] large_p;
	} partition_t;

	localparam int IDLE_LIMIT  = 400000;
	localparam int SETTLE_CYC  = 20;
	localparam int SHOW_MAX    = 10;

	logic                      clk    = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      start  = 1'b0;
	logic [gpp_pkg::NUM_W-1:0] number = '0;
	logic                      busy;
	logic                      done;
	logic [1:0]                status;
	logic [gpp_pkg::NUM_W-1:0] small_prime;
	logic [gpp_pkg::NUM_W-1:0] large_prime;

	partition_t pending_pairs[$];
	int         mismatch_count = 0;
	int         idle_cycles    = 0;
	bit         idling_on      = 1'b1;

	goldbach_prime_pair dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.number      (number),
		.done        (done),
		.status      (status),
		.small_prime (small_prime),
		.large_prime (large_prime)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// trial division primality
	function automatic bit is_prime_val(input int unsigned v);
		int unsigned d;
		if (v < gpp_pkg::MIN_PRIME)
			return 1'b0;
		for (d = gpp_pkg::MIN_PRIME; d * d <= v; d++)
			if (v % d == 0)
				return 1'b0;
		return 1'b1;
	endfunction

	// smallest-prime goldbach split of one word
	function automatic partition_t predict_partition(input logic [gpp_pkg::NUM_W-1:0] n);
		partition_t  r;
		int unsigned nv;
		int unsigned a;
		r  = '0;
		nv = n;
		if (nv <= gpp_pkg::MIN_PRIME) begin
			r.status = gpp_pkg::ST_SMALL;
		end else if (n[0]) begin
			r.status = gpp_pkg::ST_ODD;
		end else begin
			r.status = gpp_pkg::ST_PAIR;
			for (a = gpp_pkg::MIN_PRIME; a <= nv / 2; a++) begin
				if (is_prime_val(a) && is_prime_val(nv - a)) begin
					r.small_p = a[gpp_pkg::NUM_W-1:0];
					r.large_p = gpp_pkg::NUM_W'(nv - a);
					break;
				end
			end
		end
		return r;
	endfunction

	// sender gap: mostly none or short, a few long
	function automatic int pick_gap();
		int p;
		if (!idling_on)
			return 0;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		if (p < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// send one word, return at the edge that takes it
	task automatic send_word(input logic [gpp_pkg::NUM_W-1:0] n);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start  <= 1'b1;
		number <= n;
		do @(posedge clk); while (busy);
		pending_pairs.push_back(predict_partition(n));
	endtask

	// drop start and wait for every expected word
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (pending_pairs.size() != 0);
	endtask

	// result check and watchdog
	always @(posedge clk) begin
		partition_t exp_p;
		if (arst_n) begin
			if ((start && !busy) || done)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
				$display("RESULT: ERROR");
				$finish;
			end
		end
		if (done) begin
			if (pending_pairs.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= SHOW_MAX)
					$display("unexpected word: status %0d small %0d large %0d",
						status, small_prime, large_prime);
			end else begin
				exp_p = pending_pairs.pop_front();
				if (status !== exp_p.status || small_prime !== exp_p.small_p ||
						large_prime !== exp_p.large_p) begin
					mismatch_count++;
					if (mismatch_count <= SHOW_MAX)
						$display("mismatch: exp %0d/%0d/%0d got %0d/%0d/%0d",
							exp_p.status, exp_p.small_p, exp_p.large_p,
							status, small_prime, large_prime);
				end
			end
		end
	end

	// zero, one and two
	task automatic test_small_numbers();
		send_word(16'd0);
		send_word(16'd1);
		send_word(16'd2);
		drain();
	endtask

	// odd numbers from the bottom to the top of the range
	task automatic test_odd_numbers();
		send_word(16'd3);
		send_word(16'd5);
		send_word(16'd32769);
		send_word(16'd65533);
		send_word(16'd65535);
		drain();
	endtask

	// four is the only split with two equal even primes
	task automatic test_four();
		send_word(16'd4);
		send_word(16'd6);
		send_word(16'd8);
		drain();
	endtask

	// largest evens and a few with late small primes
	task automatic test_extremes();
		send_word(16'd65534);
		send_word(16'd65532);
		send_word(16'd32768);
		send_word(16'd98);
		send_word(16'd128);
		send_word(16'd1000);
		send_word(16'd16382);
		drain();
	endtask

	// mostly small evens with random gaps
	task automatic test_random_even(input int count);
		logic [gpp_pkg::NUM_W-1:0] n;
		repeat (count) begin
			n = gpp_pkg::NUM_W'($urandom_range(0, 2047));
			n[0] = 1'b0;
			send_word(n);
		end
		drain();
	endtask

	// any value, full range now and then
	task automatic test_random_mixed(input int count);
		logic [gpp_pkg::NUM_W-1:0] n;
		repeat (count) begin
			if ($urandom_range(0, 9) < 2)
				n = gpp_pkg::NUM_W'($urandom_range(0, 65535));
			else
				n = gpp_pkg::NUM_W'($urandom_range(0, 4095));
			send_word(n);
		end
		drain();
	endtask

	// start held high, one word right after another
	task automatic test_back_to_back(input int count);
		logic [gpp_pkg::NUM_W-1:0] n;
		idling_on = 1'b0;
		repeat (count) begin
			n = gpp_pkg::NUM_W'($urandom_range(0, 1023));
			send_word(n);
		end
		drain();
		idling_on = 1'b1;
	endtask

	// test sequence
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_small_numbers();
		test_odd_numbers();
		test_four();
		test_extremes();
		test_random_even(140);
		test_random_mixed(110);
		test_back_to_back(50);
		repeat (SETTLE_CYC) @(posedge clk);
		if (mismatch_count == 0 && pending_pairs.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
